// ----- rtl/ttsg_pkg.sv -----
package ttsg_pkg;

  localparam int CODE_W        = 10;
  localparam int OUT_W         = 8;
  localparam int OUT_MAX       = (1 << OUT_W) - 1;
  localparam int LEVELS_DEF    = 1024;
  localparam int FRAC_BITS_DEF = 16;

  // smoothstep unit: range check, reciprocal partial products, quotient, two multiply stages
  localparam int SMOOTH_LAT    = 5;

endpackage

// ----- rtl/ttsg_in_if.sv -----
interface ttsg_in_if import ttsg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] red_code;
  logic [CODE_W-1:0] green_code;
  logic [CODE_W-1:0] blue_code;

  modport source (output valid, output red_code, output green_code, output blue_code,
                  input ready);
  modport sink   (input valid, input red_code, input green_code, input blue_code,
                  output ready);
endinterface

// ----- rtl/ttsg_out_if.sv -----
interface ttsg_out_if import ttsg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] red_out;
  logic [OUT_W-1:0] green_out;
  logic [OUT_W-1:0] blue_out;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  output ready);
endinterface

// ----- rtl/ttsg_smooth.sv -----
module ttsg_smooth import ttsg_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int E0        = 0,
  parameter int E1        = 1
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [FRAC_BITS+1:0] x,
  output logic [FRAC_BITS+1:0] y
);

  localparam int QW = FRAC_BITS + 2;
  localparam int SW = 2 * QW + 2;
  localparam int D  = E1 - E0;
  localparam int DW = $clog2(D + 1);
  localparam int NW = DW + FRAC_BITS;
  localparam int S  = NW + DW;
  localparam int MW = NW + 2;
  localparam int LH = MW / 2;
  localparam int HW = MW - LH;

  localparam logic [S+1:0]   RECIP_W = (((S+2)'(1) << S) + (S+2)'(D) - (S+2)'(1)) / (S+2)'(D);
  localparam logic [MW-1:0]  RECIP   = MW'(RECIP_W);
  localparam logic [LH-1:0]  R_LO    = RECIP[LH-1:0];
  localparam logic [HW-1:0]  R_HI    = RECIP[MW-1:LH];

  localparam logic [NW-1:0]  H_C   = NW'(D / 2);
  localparam logic [QW-1:0]  ONE   = QW'(1) << FRAC_BITS;
  localparam logic [QW-1:0]  THREE = QW'(3) << FRAC_BITS;
  localparam logic [SW-1:0]  HALF  = SW'(1) << (FRAC_BITS - 1);

  logic             lo_c, hi_c;
  logic [NW-1:0]    num_c, num1;
  logic             lo1, hi1, lo2, hi2, lo3, hi3, lo4, hi4;
  logic [NW+LH-1:0] pl2;
  logic [NW+HW-1:0] ph2;
  logic [QW-1:0]    t_c, t3, tt_c, tt4, t4, sc_c;

  // numerator (x-E0)*2^F + D/2, zero outside the ramp
  always_comb begin
    lo_c  = (x <= QW'(E0));
    hi_c  = (x >= QW'(E1));
    num_c = (lo_c || hi_c) ? '0 : (NW'(x - QW'(E0)) << FRAC_BITS) + H_C;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num1 <= num_c;
      lo1  <= lo_c;
      hi1  <= hi_c;
    end
  end

  // reciprocal split in two halves to keep each multiplier narrow
  always_ff @(posedge clk) begin
    if (en) begin
      pl2 <= (NW+LH)'(num1) * (NW+LH)'(R_LO);
      ph2 <= (NW+HW)'(num1) * (NW+HW)'(R_HI);
      lo2 <= lo1;
      hi2 <= hi1;
    end
  end

  // floor(N/D) is exact: N*(RECIP*D - 2^S) stays below 2^S
  always_comb begin
    logic [NW+MW-1:0]  prod;
    logic [FRAC_BITS:0] q;
    prod = ((NW+MW)'(ph2) << LH) + (NW+MW)'(pl2);
    q    = prod[S +: FRAC_BITS+1];
    t_c  = (QW'(q) > ONE) ? ONE : QW'(q);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t3  <= t_c;
      lo3 <= lo2;
      hi3 <= hi2;
    end
  end

  always_comb begin
    logic [SW-1:0] p;
    p    = SW'(t3) * SW'(t3) + HALF;
    tt_c = p[FRAC_BITS +: QW];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tt4 <= tt_c;
      t4  <= t3;
      lo4 <= lo3;
      hi4 <= hi3;
    end
  end

  always_comb begin
    logic [SW-1:0] p;
    p    = SW'(tt4) * SW'(THREE - (t4 << 1)) + HALF;
    sc_c = p[FRAC_BITS +: QW];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (lo4) begin
        y <= '0;
      end else if (hi4) begin
        y <= ONE;
      end else begin
        y <= sc_c;
      end
    end
  end

endmodule

// ----- rtl/tone_tint_saturation_grade.sv -----
// channel  | dir | beat contents                          | handshake
// pixel    | in  | red_code, green_code, blue_code (10 b) | valid/ready
// graded   | out | red_out, green_out, blue_out (8 b)     | valid/ready
//
// One pixel per clock while the skid register is empty; graded.valid rises once the pixel has passed these stages:
// Sixteen stages: six to luminance, five per smoothstep (divide by reciprocal multiply),
// five to the final value, then the output register.
// rst clears the stage valid bits and the output/skid flags; data registers are not reset.
// A result waiting at the output holds; the next one drops into a skid register
// and the pipeline freezes only while that skid register is full.
module tone_tint_saturation_grade import ttsg_pkg::*; #(
  parameter int LEVELS    = LEVELS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  ttsg_in_if.sink   pixel,
  ttsg_out_if.source graded
);

  localparam int QW    = FRAC_BITS + 2;
  localparam int PW    = 2 * QW;
  localparam int SW    = PW + 2;
  localparam int TOP   = LEVELS - 1;
  localparam int TOP_W = $clog2(LEVELS);
  localparam int M_W   = CODE_W + TOP_W;
  localparam int SH    = M_W + TOP_W;
  localparam int RW    = M_W + 2;
  localparam int XW    = CODE_W + FRAC_BITS + 1;
  localparam int QD_W  = CODE_W + 1;
  localparam int OW    = FRAC_BITS + 9;
  localparam int SL    = SMOOTH_LAT;
  localparam int NST   = 11 + SL;

  localparam logic [63:0] ONE64 = 64'd1 << FRAC_BITS;
  localparam logic [63:0] A_C   = ONE64 / 64'(TOP);
  localparam logic [63:0] B_C   = ONE64 % 64'(TOP);
  localparam logic [63:0] H_TOP = 64'(TOP / 2);
  localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(TOP) - 64'd1) / 64'(TOP);

  localparam logic [63:0] K_MIX64 = ((64'd6 << FRAC_BITS) + 64'd5) / 64'd10;
  localparam logic [63:0] K_WR64  = ((64'd2126 << FRAC_BITS) + 64'd5000) / 64'd10000;
  localparam logic [63:0] K_WG64  = ((64'd7152 << FRAC_BITS) + 64'd5000) / 64'd10000;
  localparam logic [63:0] K_WB64  = ((64'd722 << FRAC_BITS) + 64'd5000) / 64'd10000;
  localparam logic [63:0] K_T064  = ((64'd2 << FRAC_BITS) + 64'd5) / 64'd10;
  localparam logic [63:0] K_T164  = ((64'd8 << FRAC_BITS) + 64'd5) / 64'd10;
  localparam logic [63:0] K_S064  = ((64'd5 << FRAC_BITS) + 64'd50) / 64'd100;
  localparam logic [63:0] K_S164  = ((64'd45 << FRAC_BITS) + 64'd50) / 64'd100;
  localparam logic [63:0] K_SLO64 = ((64'd55 << FRAC_BITS) + 64'd50) / 64'd100;
  localparam logic [63:0] K_SHI64 = ((64'd110 << FRAC_BITS) + 64'd50) / 64'd100;
  localparam logic [63:0] C_R64   = ((64'd92 << FRAC_BITS) + 64'd50) / 64'd100;
  localparam logic [63:0] C_G64   = ((64'd97 << FRAC_BITS) + 64'd50) / 64'd100;
  localparam logic [63:0] C_B64   = ((64'd110 << FRAC_BITS) + 64'd50) / 64'd100;
  localparam logic [63:0] W_R64   = ((64'd105 << FRAC_BITS) + 64'd50) / 64'd100;
  localparam logic [63:0] W_G64   = ((64'd100 << FRAC_BITS) + 64'd50) / 64'd100;
  localparam logic [63:0] W_B64   = ((64'd92 << FRAC_BITS) + 64'd50) / 64'd100;

  localparam logic [QW-1:0] ONE    = QW'(1) << FRAC_BITS;
  localparam logic [QW-1:0] THREE  = QW'(3) << FRAC_BITS;
  localparam logic [SW-1:0] HALF   = SW'(1) << (FRAC_BITS - 1);
  localparam logic [QW-1:0] K_MIX  = QW'(K_MIX64);
  localparam logic [QW-1:0] K_WR   = QW'(K_WR64);
  localparam logic [QW-1:0] K_WG   = QW'(K_WG64);
  localparam logic [QW-1:0] K_WB   = QW'(K_WB64);
  localparam logic [QW-1:0] K_SLO  = QW'(K_SLO64);
  localparam logic [QW-1:0] K_SHI  = QW'(K_SHI64);
  localparam logic [2:0][QW-1:0] COOL = {QW'(C_B64), QW'(C_G64), QW'(C_R64)};
  localparam logic [2:0][QW-1:0] WARM = {QW'(W_B64), QW'(W_G64), QW'(W_R64)};

  logic en, leaving;
  logic [NST-1:0] vld;
  logic out_v, skid_v;
  logic [2:0][OUT_W-1:0] out_px, skid_px, res_px;

  logic [2:0][CODE_W-1:0] code;

  logic [2:0][FRAC_BITS:0] ca_c, ca1;
  logic [2:0][M_W-1:0]     m_c, m1;
  logic [2:0][QW-1:0]      x_c, x2, xx_c, xx3, x3, sc_c, sc4, x4, s_c, s5, s6;
  logic [QW-1:0]           luma_c, luma6, tw, ss;
  logic [2:0][QW-1:0]      sd [SL];
  logic [2:0][QW-1:0]      tint_c, tint7, s7, sm_c, sm8, sm9;
  logic [QW-1:0]           sat_c, sat7, sat8, sat9, grey_c, grey9, dsat_c, dsat9;
  logic                    ge9, ge10;
  logic [2:0][PW-1:0]      p_c, p10;
  logic [PW-1:0]           q_c, q10;
  logic [2:0][FRAC_BITS:0] v_c, v11;

  assign en      = !skid_v;
  assign leaving = en && vld[NST-1];
  assign code    = {pixel.blue_code, pixel.green_code, pixel.red_code};

  assign pixel.ready      = en;
  assign graded.valid     = out_v;
  assign graded.red_out   = out_px[0];
  assign graded.green_out = out_px[1];
  assign graded.blue_out  = out_px[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], pixel.valid};
    end
  end

  // code/TOP split as code*(2^F div TOP) + (code*(2^F mod TOP) + TOP/2) div TOP
  always_comb begin
    logic [CODE_W-1:0] c;
    for (int ch = 0; ch < 3; ch++) begin
      c        = (32'(code[ch]) > TOP) ? CODE_W'(TOP) : code[ch];
      ca_c[ch] = (FRAC_BITS+1)'(XW'(c) * XW'(A_C));
      m_c[ch]  = M_W'(c) * M_W'(B_C) + M_W'(H_TOP);
    end
  end

  // reciprocal is exact for every remainder term below 2^M_W
  always_comb begin
    logic [M_W+RW-1:0] prod;
    logic [QW-1:0]     xs;
    for (int ch = 0; ch < 3; ch++) begin
      prod     = (M_W+RW)'(m1[ch]) * (M_W+RW)'(RECIP);
      xs       = QW'(ca1[ch]) + QW'(prod[SH +: QD_W]);
      x_c[ch]  = (xs > ONE) ? ONE : xs;
    end
  end

  always_comb begin
    logic [SW-1:0] p;
    for (int ch = 0; ch < 3; ch++) begin
      p         = SW'(x2[ch]) * SW'(x2[ch]) + HALF;
      xx_c[ch]  = p[FRAC_BITS +: QW];
    end
  end

  always_comb begin
    logic [SW-1:0] p;
    for (int ch = 0; ch < 3; ch++) begin
      p         = SW'(xx3[ch]) * SW'(THREE - (x3[ch] << 1)) + HALF;
      sc_c[ch]  = p[FRAC_BITS +: QW];
    end
  end

  always_comb begin
    logic [SW-1:0] p;
    for (int ch = 0; ch < 3; ch++) begin
      p        = SW'(x4[ch]) * SW'(ONE - K_MIX) + SW'(sc4[ch]) * SW'(K_MIX) + HALF;
      s_c[ch]  = p[FRAC_BITS +: QW];
    end
  end

  always_comb begin
    logic [SW-1:0] p;
    p      = SW'(s5[0]) * SW'(K_WR) + SW'(s5[1]) * SW'(K_WG) + SW'(s5[2]) * SW'(K_WB)
             + HALF;
    luma_c = p[FRAC_BITS +: QW];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ca1   <= ca_c;
      m1    <= m_c;
      x2    <= x_c;
      xx3   <= xx_c;
      x3    <= x2;
      sc4   <= sc_c;
      x4    <= x3;
      s5    <= s_c;
      s6    <= s5;
      luma6 <= luma_c;
      sd[0] <= s6;
      for (int k = 1; k < SL; k++) begin
        sd[k] <= sd[k-1];
      end
    end
  end

  ttsg_smooth #(
    .FRAC_BITS (FRAC_BITS),
    .E0        (int'(K_T064)),
    .E1        (int'(K_T164))
  ) u_tint_ss (
    .clk (clk),
    .en  (en),
    .x   (luma6),
    .y   (tw)
  );

  ttsg_smooth #(
    .FRAC_BITS (FRAC_BITS),
    .E0        (int'(K_S064)),
    .E1        (int'(K_S164))
  ) u_sat_ss (
    .clk (clk),
    .en  (en),
    .x   (luma6),
    .y   (ss)
  );

  always_comb begin
    logic [SW-1:0] p;
    for (int ch = 0; ch < 3; ch++) begin
      p           = SW'(COOL[ch]) * SW'(ONE - tw) + SW'(WARM[ch]) * SW'(tw) + HALF;
      tint_c[ch]  = p[FRAC_BITS +: QW];
    end
    p     = SW'(K_SLO) * SW'(ONE - ss) + SW'(K_SHI) * SW'(ss) + HALF;
    sat_c = p[FRAC_BITS +: QW];
  end

  always_comb begin
    logic [SW-1:0] p;
    for (int ch = 0; ch < 3; ch++) begin
      p         = SW'(s7[ch]) * SW'(tint7[ch]) + HALF;
      sm_c[ch]  = p[FRAC_BITS +: QW];
    end
  end

  always_comb begin
    logic [SW-1:0] p;
    p      = SW'(sm8[0]) * SW'(K_WR) + SW'(sm8[1]) * SW'(K_WG) + SW'(sm8[2]) * SW'(K_WB)
             + HALF;
    grey_c = p[FRAC_BITS +: QW];
    dsat_c = (sat8 >= ONE) ? sat8 - ONE : ONE - sat8;
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      p_c[ch] = PW'(sm9[ch]) * PW'(sat9);
    end
    q_c = PW'(grey9) * PW'(dsat9);
  end

  // grey mix at double width: push away from grey above unity, pull toward it below
  always_comb begin
    logic [PW:0] v, vr, vs;
    for (int ch = 0; ch < 3; ch++) begin
      if (ge10) begin
        v = (p10[ch] <= q10) ? '0 : (PW+1)'(p10[ch] - q10);
      end else begin
        v = (PW+1)'(p10[ch]) + (PW+1)'(q10);
      end
      vr      = v + (PW+1)'(HALF);
      vs      = vr >> FRAC_BITS;
      v_c[ch] = (vs > (PW+1)'(ONE)) ? (FRAC_BITS+1)'(ONE) : (FRAC_BITS+1)'(vs);
    end
  end

  always_comb begin
    logic [OW-1:0] o;
    for (int ch = 0; ch < 3; ch++) begin
      o          = OW'(v11[ch]) * OW'(OUT_MAX) + OW'(HALF);
      res_px[ch] = o[FRAC_BITS +: OUT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tint7 <= tint_c;
      sat7  <= sat_c;
      s7    <= sd[SL-1];
      sm8   <= sm_c;
      sat8  <= sat7;
      sm9   <= sm8;
      sat9  <= sat8;
      grey9 <= grey_c;
      dsat9 <= dsat_c;
      ge9   <= (sat8 >= ONE);
      p10   <= p_c;
      q10   <= q_c;
      ge10  <= ge9;
      v11   <= v_c;
    end
  end

  // output register with one skid slot behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (!out_v || graded.ready) begin
      if (skid_v) begin
        out_v  <= 1'b1;
        skid_v <= 1'b0;
      end else begin
        out_v <= leaving;
      end
    end else if (leaving) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v || graded.ready) begin
      if (skid_v) begin
        out_px <= skid_px;
      end else begin
        out_px <= res_px;
      end
    end else if (leaving) begin
      skid_px <= res_px;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> out_v)
    else $error("skid slot full while output register empty");

  a_stalled_beat_caught: assert property (@(posedge clk) disable iff (rst)
    (leaving && out_v && !graded.ready) |=> skid_v)
    else $error("beat leaving the pipe was not caught by the skid slot");

  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    (skid_v && !graded.ready) |=> (skid_v && $stable(skid_px)))
    else $error("skid slot changed while output stalled");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("stage valid bits moved while pipeline frozen");

endmodule
